FILE: hdl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and constants of the button gesture detector
// Button count, event codes, register indexes and the structs that travel
// between the configuration file, the button lanes and the event merger.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int BTN_W       = 3;
    localparam int SLOT_NUM    = 2 * NUM_BUTTONS;
    localparam int SLOT_W      = $clog2(SLOT_NUM);
    localparam int TIME_W      = 32;
    localparam int MS_W        = 16;
    localparam int MASK_W      = 8;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS     = 3'd0,
        KIND_DOUBLE    = 3'd1,
        KIND_LONG      = 3'd2,
        KIND_VERY_LONG = 3'd3,
        KIND_REPEAT    = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG       = 3'd1,
        REG_VERY_LONG  = 3'd2,
        REG_DOUBLE_TAP = 3'd3,
        REG_REPEAT     = 3'd4,
        REG_ACTIVE_LOW = 3'd5,
        REG_ENABLE     = 3'd6
    } cfg_idx_t;

    localparam logic [MS_W-1:0]   DEBOUNCE_RST   = 16'd30;
    localparam logic [MS_W-1:0]   LONG_RST       = 16'd500;
    localparam logic [MS_W-1:0]   VERY_LONG_RST  = 16'd1500;
    localparam logic [MS_W-1:0]   DOUBLE_TAP_RST = 16'd250;
    localparam logic [MS_W-1:0]   REPEAT_RST     = 16'd300;
    localparam logic [MASK_W-1:0] ACTIVE_LOW_RST = 8'h00;
    localparam logic [MASK_W-1:0] ENABLE_RST     = 8'hFF;

    typedef struct packed {
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   long_press_ms;
        logic [MS_W-1:0]   very_long_press_ms;
        logic [MS_W-1:0]   double_tap_ms;
        logic [MS_W-1:0]   repeat_ms;
        logic [MASK_W-1:0] active_low_mask;
        logic [MASK_W-1:0] enable_mask;
    } cfg_t;

    // events one lane found in one poll: a release or repeat event first,
    // then a single press from an expired double-tap window
    typedef struct packed {
        logic  ev0_valid;
        kind_t ev0_kind;
        logic  ev1_valid;
    } lane_ev_t;

    typedef struct packed {
        logic pend_empty;
        logic pend_one;
    } merge_status_t;

endpackage

`default_nettype wire

FILE: hdl/bgd_poll_if.sv
// ----------------------------------------------------------------------------
// bgd_poll_if: poll request channel
// Carries one timestamp and the raw button levels per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgd_poll_if;
    import bgd_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] raw_levels;

    modport source (output valid, output now_ms, output raw_levels, input ready);
    modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgd_event_if.sv
// ----------------------------------------------------------------------------
// bgd_event_if: gesture event channel
// Carries one button event per request, with the end-of-poll mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgd_event_if;
    import bgd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BTN_W-1:0]  button_index;
    logic [KIND_W-1:0] event_kind;
    logic              last_of_run;

    modport source (output valid, output button_index, output event_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input button_index, input event_kind,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgd_cfg_if.sv
// ----------------------------------------------------------------------------
// bgd_cfg_if: configuration write channel
// Carries a register index and write data per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgd_cfg_if;
    import bgd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgd_cfg_regs: configuration register file
// Holds the timing thresholds and the per-button masks.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bgd_cfg_if.sink          cfg,
    output bgd_pkg::cfg_t    regs
);
    import bgd_pkg::*;

    cfg_t regs_reg;
    logic wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid & cfg.ready;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.debounce_ms        <= DEBOUNCE_RST;
            regs_reg.long_press_ms      <= LONG_RST;
            regs_reg.very_long_press_ms <= VERY_LONG_RST;
            regs_reg.double_tap_ms      <= DOUBLE_TAP_RST;
            regs_reg.repeat_ms          <= REPEAT_RST;
            regs_reg.active_low_mask    <= ACTIVE_LOW_RST;
            regs_reg.enable_mask        <= ENABLE_RST;
        end
        else if (wr)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_DEBOUNCE:   regs_reg.debounce_ms        <= cfg.data;
                REG_LONG:       regs_reg.long_press_ms      <= cfg.data;
                REG_VERY_LONG:  regs_reg.very_long_press_ms <= cfg.data;
                REG_DOUBLE_TAP: regs_reg.double_tap_ms      <= cfg.data;
                REG_REPEAT:     regs_reg.repeat_ms          <= cfg.data;
                REG_ACTIVE_LOW: regs_reg.active_low_mask    <= cfg.data[MASK_W-1:0];
                REG_ENABLE:     regs_reg.enable_mask        <= cfg.data[MASK_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bgd_lane.sv
// ----------------------------------------------------------------------------
// bgd_lane: debouncer and gesture tracker of one button
// Updates the button state on each accepted poll while enabled and reports its events.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [bgd_pkg::TIME_W-1:0]  now_ms,
    input  wire logic                        raw_bit,
    input  wire logic                        inv_bit,
    input  wire logic                        en_bit,
    input  wire bgd_pkg::cfg_t               regs,
    output bgd_pkg::lane_ev_t                ev
);
    import bgd_pkg::*;

    logic              last_raw_reg,      last_raw_next;
    logic              stable_reg,        stable_next;
    logic [TIME_W-1:0] change_time_reg,   change_time_next;
    logic [TIME_W-1:0] press_start_reg,   press_start_next;
    logic              awaiting_reg,      awaiting_next;
    logic [TIME_W-1:0] release_time_reg,  release_time_next;
    logic              repeat_active_reg, repeat_active_next;
    logic [TIME_W-1:0] last_repeat_reg,   last_repeat_next;

    logic              lvl;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_rel;
    logic [TIME_W-1:0] since_rep;
    logic [TIME_W-1:0] rep_lim;
    logic [TIME_W-1:0] tap_lim;
    logic              deb;
    logic              rise;
    logic              fall;
    logic              opened;
    logic              ev0_valid;
    kind_t             ev0_kind;
    logic              ev1_valid;

    assign lvl          = raw_bit ^ inv_bit;
    assign ct           = (lvl != last_raw_reg) ? now_ms : change_time_reg;
    assign since_change = now_ms - ct;
    assign held         = now_ms - press_start_reg;
    assign since_rel    = now_ms - release_time_reg;
    assign since_rep    = now_ms - last_repeat_reg;
    assign rep_lim      = {{(TIME_W-MS_W){1'b0}}, regs.repeat_ms};
    assign tap_lim      = {{(TIME_W-MS_W){1'b0}}, regs.double_tap_ms};
    assign deb          = since_change > {{(TIME_W-MS_W){1'b0}}, regs.debounce_ms};
    assign rise         = deb && (lvl != stable_reg) && lvl;
    assign fall         = deb && (lvl != stable_reg) && !lvl;

    always_comb
    begin
        last_raw_next      = lvl;
        change_time_next   = ct;
        stable_next        = deb ? lvl : stable_reg;
        press_start_next   = press_start_reg;
        awaiting_next      = awaiting_reg;
        release_time_next  = release_time_reg;
        repeat_active_next = repeat_active_reg;
        last_repeat_next   = last_repeat_reg;
        ev0_valid          = 1'b0;
        ev0_kind           = KIND_PRESS;
        ev1_valid          = 1'b0;
        opened             = 1'b0;

        if (rise)
        begin
            press_start_next   = now_ms;
            repeat_active_next = 1'b0;
        end

        // classify the hold on release
        if (fall)
        begin
            if (held >= {{(TIME_W-MS_W){1'b0}}, regs.very_long_press_ms})
            begin
                ev0_valid = 1'b1;
                ev0_kind  = KIND_VERY_LONG;
            end
            else if (held >= {{(TIME_W-MS_W){1'b0}}, regs.long_press_ms})
            begin
                ev0_valid = 1'b1;
                ev0_kind  = KIND_LONG;
            end
            else if (awaiting_reg && (since_rel < tap_lim))
            begin
                ev0_valid     = 1'b1;
                ev0_kind      = KIND_DOUBLE;
                awaiting_next = 1'b0;
            end
            else
            begin
                awaiting_next     = 1'b1;
                release_time_next = now_ms;
                opened            = 1'b1;
            end
        end

        // auto-repeat while held; a fresh press has zero hold time
        if (deb && stable_next && !rise)
        begin
            if (!repeat_active_reg)
            begin
                if (held > rep_lim)
                begin
                    ev0_valid          = 1'b1;
                    ev0_kind           = KIND_REPEAT;
                    last_repeat_next   = now_ms;
                    repeat_active_next = 1'b1;
                end
            end
            else if (since_rep > rep_lim)
            begin
                ev0_valid        = 1'b1;
                ev0_kind         = KIND_REPEAT;
                last_repeat_next = now_ms;
            end
        end

        // expired window while released: a single press
        if (awaiting_next && !opened && !stable_next && (since_rel > tap_lim))
        begin
            ev1_valid     = 1'b1;
            awaiting_next = 1'b0;
        end
    end

    assign ev.ev0_valid = ev0_valid & en_bit;
    assign ev.ev0_kind  = ev0_kind;
    assign ev.ev1_valid = ev1_valid & en_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg      <= 1'b0;
            stable_reg        <= 1'b0;
            change_time_reg   <= '0;
            press_start_reg   <= '0;
            awaiting_reg      <= 1'b0;
            release_time_reg  <= '0;
            repeat_active_reg <= 1'b0;
            last_repeat_reg   <= '0;
        end
        else if (step && en_bit)
        begin
            last_raw_reg      <= last_raw_next;
            stable_reg        <= stable_next;
            change_time_reg   <= change_time_next;
            press_start_reg   <= press_start_next;
            awaiting_reg      <= awaiting_next;
            release_time_reg  <= release_time_next;
            repeat_active_reg <= repeat_active_next;
            last_repeat_reg   <= last_repeat_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bgd_merge.sv
// ----------------------------------------------------------------------------
// bgd_merge: event merger
// Latches the lane events of one poll and sends them out in button order.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_merge (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      step,
    input  wire bgd_pkg::lane_ev_t [bgd_pkg::NUM_BUTTONS-1:0] lane_ev,
    output logic                                           take,
    output bgd_pkg::merge_status_t                         status,
    bgd_event_if.source                                    evt
);
    import bgd_pkg::*;

    logic [SLOT_NUM-1:0] pend_reg, pend_next;
    kind_t [NUM_BUTTONS-1:0] kind_reg;
    logic                out_valid_reg;
    logic [BTN_W-1:0]    out_btn_reg;
    kind_t               out_kind_reg;
    logic                out_last_reg;

    logic                load;
    logic [SLOT_W-1:0]   sel;
    logic [SLOT_NUM-1:0] sel_hot;
    logic                pend_empty;
    logic                pend_one;
    logic [SLOT_NUM-1:0] fresh;

    // lowest pending slot first
    always_comb
    begin
        sel = '0;
        for (int i = SLOT_NUM - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            fresh[2*b]   = lane_ev[b].ev0_valid;
            fresh[2*b+1] = lane_ev[b].ev1_valid;
        end
    end

    assign sel_hot    = SLOT_NUM'(1) << sel;
    assign pend_empty = (pend_reg == '0);
    assign pend_one   = !pend_empty && ((pend_reg & (pend_reg - SLOT_NUM'(1))) == '0);
    assign load       = !pend_empty && (!out_valid_reg || evt.ready);
    assign take       = pend_empty || (pend_one && load);

    assign status.pend_empty = pend_empty;
    assign status.pend_one   = pend_one;

    always_comb
    begin
        pend_next = pend_reg;
        if (load)
        begin
            pend_next = pend_next & ~sel_hot;
        end
        if (step)
        begin
            pend_next = pend_next | fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                kind_reg[b] <= lane_ev[b].ev0_kind;
            end
        end
        if (load)
        begin
            out_btn_reg  <= sel[SLOT_W-1:1];
            out_kind_reg <= sel[0] ? KIND_PRESS : kind_reg[sel[SLOT_W-1:1]];
            out_last_reg <= ((pend_reg & ~sel_hot) == '0);
        end
    end

    assign evt.valid        = out_valid_reg;
    assign evt.button_index = out_btn_reg;
    assign evt.event_kind   = out_kind_reg;
    assign evt.last_of_run  = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/button_gesture_detector_top.sv
// An accepted poll's events are latched into the pending slots of the merger,
// then moved into the output register, one event per cycle while the sink is
// ready. One poll is taken per cycle while polls cause no events; otherwise a
// poll waits until the merger holds at most one of its up to 16 pending events.
// Reset puts all control state to its reset value at once: no sweep.
// ----------------------------------------------------------------------------
// button_gesture_detector_top: debounced button gesture detector
// Eight button lanes track debounce, press, double press, long, very long and
// auto-repeat in parallel; a merger sends their events in button order.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bgd_poll_if.sink    poll,
    bgd_cfg_if.sink     cfg,
    bgd_event_if.source evt
);
    import bgd_pkg::*;

    cfg_t                         regs;
    lane_ev_t [NUM_BUTTONS-1:0]   lane_ev;
    merge_status_t                mst;
    logic                         take;
    logic                         step;

    // Take a poll request once the merger holds at most the event it is
    // handing out this cycle; a waiting output event blocks only while one event is pending.
    assign poll.ready = take;
    assign step       = poll.valid & take;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    bgd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // One lane per button. Each advances its own state on every accepted
    // poll when enabled and holds it frozen when disabled.
    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        bgd_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (step),
            .now_ms  (poll.now_ms),
            .raw_bit (poll.raw_levels[b]),
            .inv_bit (regs.active_low_mask[b]),
            .en_bit  (regs.enable_mask[b]),
            .regs    (regs),
            .ev      (lane_ev[b])
        );
    end

    // Merge lane events into one ordered stream with the end-of-poll mark.
    bgd_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .lane_ev (lane_ev),
        .take    (take),
        .status  (mst),
        .evt     (evt)
    );

    // A poll never lands on top of undelivered events of an earlier poll.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (poll.valid && poll.ready) |-> (mst.pend_empty || mst.pend_one))
        else $error("poll accepted while events of an earlier poll are pending");

    // An event without the end mark always has a successor queued.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && !evt.last_of_run) |-> !mst.pend_empty)
        else $error("event not marked last but nothing follows");

    // Hold a stalled event request steady until the sink takes it.
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && !evt.ready) |=> (evt.valid && $stable(evt.button_index)
            && $stable(evt.event_kind) && $stable(evt.last_of_run)))
        else $error("event request changed while stalled");

endmodule

`default_nettype wire
